FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands used by the datapath module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sosm_pkg.sv
// ----------------------------------------------------------------------------
// Sequence merge package
// Word types, operation codes and the command and status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sosm_pkg;

   localparam int CHANNELS_DEFAULT = 256;
   localparam int SEQ_W            = 31;
   localparam int CHAN_W           = 8;
   localparam int ACC_W            = 32;
   localparam int ACT_W            = 9;
   localparam logic [ACT_W-1:0] ACTIVE_RESET = 9'd256;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SELECT = 1'b1
   } sosm_op_type;

   typedef struct packed {
      sosm_op_type        operation;
      logic [CHAN_W-1:0]  channel;
      logic [SEQ_W-1:0]   sequence_req;
   } sosm_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        selected_channel;
      logic [SEQ_W-1:0]         selected_sequence;
      logic signed [ACC_W-1:0]  gap;
      logic signed [ACC_W-1:0]  dropped_total;
      logic                     done_res;
   } sosm_rsp_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic scan_init;
      logic scan_rd;
      logic diff;
      logic report;
   } sosm_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_last;
   } sosm_sts_type;

endpackage

`default_nettype wire

FILE: src/sequence_ordered_stream_merge.sv
// ----------------------------------------------------------------------------
// Sequence ordered stream merge
// K-way merge by sequence number over per-channel head values.
// ----------------------------------------------------------------------------
// A load word writes one channel head (a channel at or above CHANNELS is
// ignored). A select word scans heads 0 .. N-1 (N is the clamped active
// channel count) out of a single-port head memory, one head per cycle, then
// runs the drain, diff and report states; busy is low again in the cycle
// the result is shown. The result strobe is high for exactly one cycle and
// the receiver cannot stall it. After reset the block is busy while it
// sweeps the head memory to zero; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sequence_ordered_stream_merge #(
   parameter int CHANNELS = sosm_pkg::CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  sosm_pkg::sosm_req_type     req_data,
   input  logic                       csr_wr_en,
   input  logic [sosm_pkg::ACT_W-1:0] csr_wr_data,
   output logic                       rsp_valid,
   output sosm_pkg::sosm_rsp_type     rsp_data
);
   import sosm_pkg::*;

   sosm_cmd_type cmd;
   sosm_sts_type sts;

   sosm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .busy      (busy),
      .cmd       (cmd),
      .sts       (sts)
   );

   sosm_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

FILE: src/sosm_ctrl.sv
// ----------------------------------------------------------------------------
// Sequence merge controller
// Sequences the clearing pass, head loads and the per-select scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sosm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sosm_pkg::sosm_op_type operation,
   output logic                  busy,
   output sosm_pkg::sosm_cmd_type cmd,
   input  sosm_pkg::sosm_sts_type sts
);
   import sosm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DRAIN,
      ST_DIFF,
      ST_REPORT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (operation == OP_SELECT) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: src/sosm_dp.sv
// ----------------------------------------------------------------------------
// Sequence merge datapath
// Head memory, scan compare, gap and drop accounting, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sosm_dp #(
   parameter int CHANNELS = sosm_pkg::CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sosm_pkg::sosm_cmd_type        cmd,
   output sosm_pkg::sosm_sts_type        sts,
   input  sosm_pkg::sosm_req_type        req_data,
   input  logic                          csr_wr_en,
   input  logic [sosm_pkg::ACT_W-1:0]    csr_wr_data,
   output logic                          rsp_valid,
   output sosm_pkg::sosm_rsp_type        rsp_data
);
   import sosm_pkg::*;

   localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IW  = ((AW > CHAN_W) ? AW : CHAN_W) + 1;
   localparam int NWC = $clog2(CHANNELS + 1);
   localparam int NW  = (NWC > ACT_W) ? NWC : ACT_W;

   logic [SEQ_W-1:0] heads_mem [CHANNELS];
   logic [SEQ_W-1:0] rd_data_ff;

   logic [ACT_W-1:0] active_ff, active_in;
   logic [AW-1:0]    cnt_ff, cnt_in;
   logic [AW-1:0]    last_ff, last_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic [SEQ_W-1:0] best_ff, best_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   logic             found_ff, found_in;
   logic [ACC_W-1:0] gap_ff, gap_in;
   logic [ACC_W-1:0] next_ff, next_in;
   logic [ACC_W-1:0] drop_ff, drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sosm_rsp_type     rsp_ff, rsp_in;

   logic [IW-1:0]    ch_ext;
   logic             ld_ok;
   logic [NW-1:0]    act_ext;
   logic [NW-1:0]    scan_n;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [SEQ_W-1:0] wr_data;

   assign ch_ext  = IW'(req_data.channel);
   assign ld_ok   = (ch_ext < IW'(CHANNELS));
   assign act_ext = NW'(active_ff);

   always_comb begin
      priority if (act_ext == '0) begin
         scan_n = NW'(1);
      end else if (act_ext > NW'(CHANNELS)) begin
         scan_n = NW'(CHANNELS);
      end else begin
         scan_n = act_ext;
      end
   end

   always_comb begin
      wr_en   = cmd.clr || (cmd.load && ld_ok);
      wr_addr = cmd.clr ? cnt_ff : ch_ext[AW-1:0];
      wr_data = cmd.clr ? '0 : req_data.sequence_req;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heads_mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= heads_mem[cnt_ff];
      end
   end

   always_comb begin
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rd_valid_in  = cmd.scan_rd;
      rd_idx_in    = cnt_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      gap_in       = gap_ff;
      next_in      = next_ff;
      drop_in      = drop_ff;
      rsp_valid_in = cmd.report;
      rsp_in       = rsp_ff;

      if (csr_wr_en) begin
         active_in = csr_wr_data;
      end

      // fold the nonzero word read last cycle into the running minimum
      if (rd_valid_ff && (rd_data_ff != '0) && (!found_ff || (rd_data_ff < best_ff))) begin
         best_in     = rd_data_ff;
         best_idx_in = rd_idx_ff;
         found_in    = 1'b1;
      end

      if (cmd.scan_init) begin
         cnt_in   = '0;
         last_in  = AW'(scan_n - NW'(1));
         found_in = 1'b0;
      end

      if (cmd.clr || cmd.scan_rd) begin
         cnt_in = cnt_ff + AW'(1);
      end

      if (cmd.diff) begin
         gap_in = found_ff ? ({1'b0, best_ff} - next_ff) : '0;
      end

      if (cmd.report) begin
         drop_in = drop_ff + gap_ff;
         if (found_ff) begin
            next_in = {1'b0, best_ff} + ACC_W'(1);
         end
         rsp_in.selected_channel  = found_ff ? CHAN_W'(best_idx_ff) : '0;
         rsp_in.selected_sequence = found_ff ? best_ff : '0;
         rsp_in.gap               = gap_ff;
         rsp_in.dropped_total     = drop_ff + gap_ff;
         rsp_in.done_res          = !found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         next_ff      <= ACC_W'(1);
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         next_ff      <= next_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      gap_ff      <= gap_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.clr_last  = (cnt_ff == AW'(CHANNELS - 1));
   assign sts.scan_last = (cnt_ff == last_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   `ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `ASSERT_IMPLY(a_no_read_at_report, rsp_valid_ff, !rd_valid_ff, "read in flight at result")
   `ASSERT_IMPLY(a_done_clean, rsp_valid_ff && rsp_ff.done_res,
      (rsp_ff.gap == '0) && (rsp_ff.selected_sequence == '0), "done result not clean")
   `ASSERT_IMPLY(a_found_nonzero, rsp_valid_ff && !rsp_ff.done_res,
      rsp_ff.selected_sequence != '0, "selected sequence is zero")

endmodule

`default_nettype wire
